// ===== sv/pixel_arith_clamp_unit_macros.svh =====
// assertion macros shared by the pixel arithmetic rtl
`ifndef PIXEL_ARITH_CLAMP_UNIT_MACROS_SVH
`define PIXEL_ARITH_CLAMP_UNIT_MACROS_SVH

// condition that must hold at every clock out of reset
`define PAC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define PAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/pac_pkg.sv =====
// shared types and constants of the pixel arithmetic unit
`default_nettype none
package pac_pkg;
  localparam int PIX_W         = 25;
  localparam int DEN_W         = 26;
  localparam int RES_W         = 51;
  localparam int FRAC_BITS_DEF = 16;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;
  localparam int PIX_MAX_I     = 2 ** (PIX_W - 1) - 1;
  localparam int PIX_MIN_I     = -(2 ** (PIX_W - 1));

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic signed [DEN_W-1:0] den_t;
  typedef logic signed [RES_W-1:0] res_t;

  typedef enum logic [2:0] {
    OP_ADD_S, OP_MUL_S, OP_DIV_S, OP_ADD, OP_SUB, OP_MUL, OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    REG_SCALAR, REG_SKIP, REG_BIAS
  } reg_idx_t;

  // sideband that travels beside the divider
  typedef struct packed {
    logic valid_op;
    logic clamp;
    logic dz;
    logic is_div;
    logic q_neg;
    logic last;
    res_t val;
  } side_t;
endpackage
`default_nettype wire

// ===== sv/pac_front.sv =====
// operand select, adder, multiplier and divider setup
`default_nettype none
module pac_front #(
  parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [2:0]                         in_op,
  input  wire pac_pkg::pix_t                      in_a,
  input  wire pac_pkg::pix_t                      in_b,
  input  wire logic                               in_last,
  input  wire pac_pkg::pix_t                      scalar,
  input  wire logic                               skip_clamp,
  input  wire logic [15:0]                        bias,
  output logic                                    out_valid,
  output logic [pac_pkg::PIX_W+FRAC_BITS-1:0]     out_num,
  output logic [pac_pkg::DEN_W-1:0]               out_den,
  output pac_pkg::side_t                          out_side
);
  localparam int PW = pac_pkg::PIX_W;
  localparam int DW = pac_pkg::DEN_W;
  localparam int QW = pac_pkg::PIX_W + FRAC_BITS;
  localparam int MW = pac_pkg::PIX_W + pac_pkg::DEN_W;

  // stage 1: operand select
  logic              v1_r, v1_nxt;
  logic [2:0]        op_r;
  pac_pkg::pix_t     a_r;
  pac_pkg::den_t     d_r, d_nxt;
  logic              clamp_r, clamp_nxt;
  logic              last_r;

  always_comb begin
    v1_nxt    = in_valid;
    d_nxt     = pac_pkg::den_t'(in_b);
    clamp_nxt = 1'b1;
    case (pac_pkg::op_t'(in_op))
      pac_pkg::OP_ADD_S, pac_pkg::OP_MUL_S, pac_pkg::OP_DIV_S: begin
        d_nxt     = pac_pkg::den_t'(scalar);
        clamp_nxt = ~skip_clamp;
      end
      pac_pkg::OP_DIV: begin
        d_nxt = pac_pkg::den_t'(in_b) + pac_pkg::den_t'({1'b0, bias});
      end
      default: begin
        d_nxt = pac_pkg::den_t'(in_b);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r    <= in_op;
      a_r     <= in_a;
      d_r     <= d_nxt;
      clamp_r <= clamp_nxt;
      last_r  <= in_last;
    end
  end

  // stage 2: arithmetic
  logic signed [MW-1:0] prod;
  pac_pkg::res_t        mul_val, sum_val, dz_val;
  logic [PW-1:0]        abs_a;
  logic [DW-1:0]        abs_d;
  logic                 dz;
  pac_pkg::side_t       side_nxt;
  logic                 v2_r;
  logic [QW-1:0]        num_r;
  logic [DW-1:0]        den_r;
  pac_pkg::side_t       side_r;

  always_comb begin
    prod    = a_r * d_r;
    mul_val = pac_pkg::res_t'(prod >>> FRAC_BITS);
    abs_a   = a_r[PW-1] ? PW'(-a_r) : PW'(a_r);
    abs_d   = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
    dz      = (d_r == '0);
    if (a_r[PW-1]) begin
      dz_val = pac_pkg::res_t'(pac_pkg::PIX_MIN_I);
    end else if (a_r != '0) begin
      dz_val = pac_pkg::res_t'(pac_pkg::PIX_MAX_I);
    end else begin
      dz_val = '0;
    end
    sum_val = pac_pkg::res_t'(a_r) + pac_pkg::res_t'(d_r);

    side_nxt.valid_op = 1'b1;
    side_nxt.clamp    = clamp_r;
    side_nxt.dz       = 1'b0;
    side_nxt.is_div   = 1'b0;
    side_nxt.q_neg    = a_r[PW-1] ^ d_r[DW-1];
    side_nxt.last     = last_r;
    side_nxt.val      = '0;
    case (pac_pkg::op_t'(op_r))
      pac_pkg::OP_ADD_S, pac_pkg::OP_ADD: begin
        side_nxt.val = sum_val;
      end
      pac_pkg::OP_SUB: begin
        side_nxt.val = pac_pkg::res_t'(a_r) - pac_pkg::res_t'(d_r);
      end
      pac_pkg::OP_MUL_S, pac_pkg::OP_MUL: begin
        side_nxt.val = mul_val;
      end
      pac_pkg::OP_DIV_S, pac_pkg::OP_DIV: begin
        side_nxt.is_div = 1'b1;
        side_nxt.dz     = dz;
        side_nxt.val    = dz_val;
      end
      default: begin
        side_nxt.valid_op = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= {abs_a, {FRAC_BITS{1'b0}}};
      den_r  <= abs_d;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r;
endmodule
`default_nettype wire

// ===== sv/pac_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module pac_div #(
  parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [pac_pkg::PIX_W+FRAC_BITS-1:0] in_num,
  input  wire logic [pac_pkg::DEN_W-1:0]          in_den,
  input  wire pac_pkg::side_t                     in_side,
  output logic                                    out_valid,
  output logic [pac_pkg::PIX_W+FRAC_BITS-1:0]     out_quo,
  output pac_pkg::side_t                          out_side
);
  localparam int QW = pac_pkg::PIX_W + FRAC_BITS;
  localparam int DW = pac_pkg::DEN_W;

  logic                v_s   [QW+1];
  logic [QW-1:0]       n_s   [QW+1];
  logic [QW-1:0]       q_s   [QW+1];
  logic [DW-1:0]       rem_s [QW+1];
  logic [DW-1:0]       den_s [QW+1];
  pac_pkg::side_t      side_s[QW+1];

  assign v_s[0]    = in_valid;
  assign n_s[0]    = in_num;
  assign q_s[0]    = '0;
  assign rem_s[0]  = '0;
  assign den_s[0]  = in_den;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic          v_r;
    logic [QW-1:0] n_r, q_r;
    logic [DW-1:0] rem_r, den_r;
    pac_pkg::side_t side_r;

    always_comb begin
      trial   = {rem_s[i], n_s[i][QW-1]} - {1'b0, den_s[i]};
      ge      = ~trial[DW];
      rem_nxt = ge ? trial[DW-1:0] : {rem_s[i][DW-2:0], n_s[i][QW-1]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r    <= {n_s[i][QW-2:0], 1'b0};
        q_r    <= {q_s[i][QW-2:0], ge};
        rem_r  <= rem_nxt;
        den_r  <= den_s[i];
        side_r <= side_s[i];
      end
    end

    assign v_s[i+1]    = v_r;
    assign n_s[i+1]    = n_r;
    assign q_s[i+1]    = q_r;
    assign rem_s[i+1]  = rem_r;
    assign den_s[i+1]  = den_r;
    assign side_s[i+1] = side_r;
  end

  assign out_valid = v_s[QW];
  assign out_quo   = q_s[QW];
  assign out_side  = side_s[QW];
endmodule
`default_nettype wire

// ===== sv/pac_sat.sv =====
// result select, clamp or saturate, and output register
`default_nettype none
`include "pixel_arith_clamp_unit_macros.svh"
module pac_sat #(
  parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [pac_pkg::PIX_W+FRAC_BITS-1:0] in_quo,
  input  wire pac_pkg::side_t                     in_side,
  output logic                                    out_valid,
  output pac_pkg::pix_t                           out_pixel,
  output logic                                    out_ovf,
  output logic                                    out_dz,
  output logic                                    out_last
);
  localparam int PW = pac_pkg::PIX_W;
  localparam int RW = pac_pkg::RES_W;
  localparam int QW = pac_pkg::PIX_W + FRAC_BITS;
  localparam pac_pkg::res_t R_MAX = pac_pkg::res_t'(pac_pkg::PIX_MAX_I);
  localparam pac_pkg::res_t R_MIN = pac_pkg::res_t'(pac_pkg::PIX_MIN_I);
  localparam pac_pkg::res_t R_ONE =
    (FRAC_BITS >= PW - 1) ? R_MAX : pac_pkg::res_t'(2 ** FRAC_BITS);

  pac_pkg::res_t qmag, r, r_lim;
  logic          ovf_nxt, dz_nxt;
  logic          vld_r, ovf_r, dz_r, last_r, clamp_r;
  pac_pkg::pix_t pix_r;

  always_comb begin
    qmag    = pac_pkg::res_t'({{(RW-QW){1'b0}}, in_quo});
    r       = (in_side.is_div && !in_side.dz)
              ? (in_side.q_neg ? -qmag : qmag) : in_side.val;
    r_lim   = '0;
    ovf_nxt = 1'b0;
    dz_nxt  = 1'b0;
    if (in_side.valid_op) begin
      dz_nxt = in_side.dz;
      if (in_side.clamp) begin
        if (r < 0) begin
          r_lim = '0;
        end else if (r > R_ONE) begin
          r_lim = R_ONE;
        end else begin
          r_lim = r;
        end
      end else begin
        if (r > R_MAX) begin
          r_lim   = R_MAX;
          ovf_nxt = 1'b1;
        end else if (r < R_MIN) begin
          r_lim   = R_MIN;
          ovf_nxt = 1'b1;
        end else begin
          r_lim   = r;
        end
        if (in_side.dz && r != 0) begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r   <= r_lim[PW-1:0];
      ovf_r   <= ovf_nxt;
      dz_r    <= dz_nxt;
      last_r  <= in_side.last;
      clamp_r <= in_side.clamp & in_side.valid_op;
    end
  end

  assign out_valid = vld_r;
  assign out_pixel = pix_r;
  assign out_ovf   = ovf_r;
  assign out_dz    = dz_r;
  assign out_last  = last_r;

  `PAC_ASSERT_IMP(a_ovf_at_limit, vld_r && ovf_r,
    pix_r == pac_pkg::pix_t'(pac_pkg::PIX_MAX_I) || pix_r == pac_pkg::pix_t'(pac_pkg::PIX_MIN_I),
    "overflow flagged on a value that is not a limit")
  `PAC_ASSERT_IMP(a_ovf_not_clamped, vld_r && clamp_r, !ovf_r,
    "overflow flagged on a clamped result")
  `PAC_ASSERT_IMP(a_dz_value, vld_r && dz_r && !ovf_r,
    pix_r == '0 || pix_r == R_ONE[PW-1:0],
    "zero divisor gave an unexpected value")
endmodule
`default_nettype wire

// ===== sv/pixel_arith_clamp_unit.sv =====
// top level of the pixel arithmetic unit: config registers and stream stages
// usage:
//   in_* stream carries one sample per transaction: in_tuser is the op,
//   in_tdata holds pixel_a and pixel_b, in_tlast marks the last sample.
//   out_* stream returns one result per input transaction, in order:
//   out_tdata holds pixel_out, out_tuser the overflow and zero divisor flags,
//   out_tlast copies in_tlast.
//   cfg_* is an apb port with scalar_operand at 0x0, skip_clamp at 0x4 and
//   divide_bias at 0x8; write it only while no transaction is in flight.
// the pipe has two front stages for operand select and arithmetic, one
// divider stage per quotient bit, and the output register.
// throughput is one transaction per cycle while the output is not stalled; the whole pipe advances together.
// when out_tready is low with a result waiting, every stage holds and
// in_tready drops the same cycle; nothing is lost or repeated.
// reset (rst_n low, synchronous) empties the pipe and sets scalar_operand to
// 1.0, skip_clamp to 0 and divide_bias to 1.
`default_nettype none
`include "pixel_arith_clamp_unit_macros.svh"
module pixel_arith_clamp_unit #(
  parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [55:0]                 in_tdata,   // pixel_a, pixel_b, zero pad
  input  wire logic [2:0]                  in_tuser,   // op
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,  // pixel_out, zero pad
  output logic [1:0]                       out_tuser,  // overflowed, divided_by_zero
  output logic                             out_tlast,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [pac_pkg::APB_AW-1:0]  cfg_paddr,
  input  wire logic [pac_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [pac_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  localparam int PW = pac_pkg::PIX_W;
  localparam int QW = pac_pkg::PIX_W + FRAC_BITS;
  localparam int DW = pac_pkg::DEN_W;

  pac_pkg::pix_t scalar_r;
  logic          skip_r;
  logic [15:0]   bias_r;
  logic          wr_en;
  pac_pkg::reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = pac_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scalar_r <= pac_pkg::pix_t'(2 ** FRAC_BITS > pac_pkg::PIX_MAX_I
                                  ? pac_pkg::PIX_MAX_I : 2 ** FRAC_BITS);
      skip_r   <= 1'b0;
      bias_r   <= 16'd1;
    end else if (wr_en) begin
      unique case (idx)
        pac_pkg::REG_SCALAR: scalar_r <= cfg_pwdata[PW-1:0];
        pac_pkg::REG_SKIP:   skip_r   <= cfg_pwdata[0];
        pac_pkg::REG_BIAS:   bias_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pac_pkg::REG_SCALAR: cfg_prdata = pac_pkg::APB_DW'(scalar_r);
      pac_pkg::REG_SKIP:   cfg_prdata = pac_pkg::APB_DW'(skip_r);
      pac_pkg::REG_BIAS:   cfg_prdata = pac_pkg::APB_DW'(bias_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // whole pipe moves unless a finished result is stuck at the output
  logic en;
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  logic           f_valid, d_valid;
  logic [QW-1:0]  f_num, d_quo;
  logic [DW-1:0]  f_den;
  pac_pkg::side_t f_side, d_side;
  pac_pkg::pix_t  pix;
  logic           ovf, dz;

  pac_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid & in_tready),
    .in_op      (in_tuser),
    .in_a       (in_tdata[24:0]),
    .in_b       (in_tdata[49:25]),
    .in_last    (in_tlast),
    .scalar     (scalar_r),
    .skip_clamp (skip_r),
    .bias       (bias_r),
    .out_valid  (f_valid),
    .out_num    (f_num),
    .out_den    (f_den),
    .out_side   (f_side)
  );

  pac_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  pac_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_quo    (d_quo),
    .in_side   (d_side),
    .out_valid (out_tvalid),
    .out_pixel (pix),
    .out_ovf   (ovf),
    .out_dz    (dz),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, pix};
  assign out_tuser = {dz, ovf};

  `PAC_ASSERT(a_ready_follows_stall, in_tready == (!out_tvalid || out_tready),
    "input side not tied to output stall")
endmodule
`default_nettype wire

// ===== dv/pixel_arith_clamp_unit_tb.sv =====
// self-checking stream testbench for the pixel arithmetic clamp unit
`timescale 1ns / 100ps
module pixel_arith_clamp_unit_tb;

  localparam int FB      = 16;
  localparam int LAT     = 3 + 25 + FB;
  localparam int N_RAND  = 1050;
  localparam longint PMAX = 64'sd16777215;
  localparam longint PMIN = -64'sd16777216;
  localparam longint ONE  = 64'sd65536;

  typedef struct packed {
    logic [24:0] pix;
    logic        ovf;
    logic        dz;
    logic        last;
  } result_t;

  typedef struct {
    logic [2:0]  op;
    logic [24:0] a;
    logic [24:0] b;
    logic        last;
    logic        known;   // expected result typed in below
    result_t     res;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [pac_pkg::APB_AW-1:0] cfg_paddr = '0;
  logic [pac_pkg::APB_DW-1:0] cfg_pwdata = '0;
  logic [pac_pkg::APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  pixel_arith_clamp_unit i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers
  longint scalar_q = ONE;
  logic   skip_q   = 1'b0;
  longint bias_q   = 1;

  result_t expected_q[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0, n_dz = 0, n_ovf = 0;
  logic stall_hold = 1'b0;

  function automatic longint sx(logic [24:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FB;   // arithmetic shift floors toward minus infinity
  endfunction

  function automatic result_t pixel_compute(logic [2:0] op, logic [24:0] ua,
                                            logic [24:0] ub, logic last);
    result_t o;
    longint a, b, r, d;
    logic clamp, dz, ovf, ok;
    a = sx(ua); b = sx(ub);
    r = 0; d = 0; clamp = 1'b1; dz = 1'b0; ovf = 1'b0; ok = 1'b1;
    case (op)
      pac_pkg::OP_ADD_S: begin r = a + scalar_q; clamp = !skip_q; end
      pac_pkg::OP_MUL_S: begin r = fx_mul(a, scalar_q); clamp = !skip_q; end
      pac_pkg::OP_DIV_S: begin d = scalar_q; clamp = !skip_q; end
      pac_pkg::OP_ADD:   r = a + b;
      pac_pkg::OP_SUB:   r = a - b;
      pac_pkg::OP_MUL:   r = fx_mul(a, b);
      pac_pkg::OP_DIV:   d = b + bias_q;
      default:  ok = 1'b0;
    endcase
    if (op == pac_pkg::OP_DIV_S || op == pac_pkg::OP_DIV) begin
      if (d == 0) begin
        dz = 1'b1;
        r = (a > 0) ? PMAX : (a < 0) ? PMIN : 0;
      end else begin
        r = (a * (64'sd1 << FB)) / d;
      end
    end
    if (ok) begin
      if (clamp) begin
        if (r < 0) r = 0;
        else if (r > ONE) r = ONE;
      end else begin
        if (r > PMAX) begin r = PMAX; ovf = 1'b1; end
        else if (r < PMIN) begin r = PMIN; ovf = 1'b1; end
        if (dz && r != 0) ovf = 1'b1;
      end
    end
    o.pix = r[24:0]; o.ovf = ovf; o.dz = dz; o.last = last;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch %s got %0h want %0h at result %0d", what, got, want, n_recv);
    errors++;
  endtask

  // drops in_tvalid only when a real gap follows
  task automatic rand_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_sample(logic [2:0] op, logic [24:0] a, logic [24:0] b, logic last);
    expected_q.push_back(pixel_compute(op, a, b, last));
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, b, a};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    rand_gap();
  endtask

  task automatic reg_write(pac_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= pac_pkg::APB_AW'(idx) << 2;
    cfg_pwdata <= v; cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      pac_pkg::REG_SCALAR: scalar_q = sx(v[24:0]);
      pac_pkg::REG_SKIP:   skip_q = v[0];
      default:    bias_q = longint'(v[15:0]);
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [24:0] rand_pix();
    case ($urandom_range(0, 5))
      0: return 25'h0FFFFFF;
      1: return 25'h1000000;
      2: return 25'($urandom_range(0, 131072));
      3: return 25'($signed(-$urandom_range(0, 131072)));
      4: return 25'($urandom_range(0, 3)) + 25'h0010000 - 25'd2;
      default: return 25'($urandom());
    endcase
  endfunction

  // receiver: random back-pressure plus an occasional long hold
  always @(posedge clk) begin
    if (!rst_n || stall_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7);
  end

  initial begin
    stall_hold = 1'b1;
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    stall_hold = 1'b0;
    repeat (4000) @(posedge clk);
    stall_hold = 1'b1;
    repeat (200) @(posedge clk);
    stall_hold = 1'b0;
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      n_recv++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_tdata[24:0] !== w.pix) report_mismatch("pixel_out", out_tdata[24:0], w.pix);
        if (out_tdata[31:25] !== 7'b0) report_mismatch("tdata pad", out_tdata[31:25], 0);
        if (out_tuser[0] !== w.ovf) report_mismatch("overflowed", out_tuser[0], w.ovf);
        if (out_tuser[1] !== w.dz) report_mismatch("divided_by_zero", out_tuser[1], w.dz);
        if (out_tlast !== w.last) report_mismatch("last", out_tlast, w.last);
        if (w.dz) n_dz++;
        if (w.ovf) n_ovf++;
      end
    end
  end

  stim_t dir_tab[] = '{
    // after reset: add 1.0 then clamp
    '{3'(pac_pkg::OP_ADD_S), 25'h0000000, 25'h0, 1'b0, 1'b1,
      '{25'h0010000, 1'b0, 1'b0, 1'b0}},
    '{3'(pac_pkg::OP_ADD_S), 25'h1000000, 25'h0, 1'b1, 1'b1,
      '{25'h0000000, 1'b0, 1'b0, 1'b1}},
    '{3'(pac_pkg::OP_MUL_S), 25'h0FFFFFF, 25'h0, 1'b0, 1'b1,
      '{25'h0010000, 1'b0, 1'b0, 1'b0}},
    '{3'(pac_pkg::OP_DIV_S), 25'h0008000, 25'h0, 1'b0, 1'b1,
      '{25'h0008000, 1'b0, 1'b0, 1'b0}},
    '{3'(pac_pkg::OP_ADD), 25'h0FFFFFF, 25'h0FFFFFF, 1'b0, 1'b1,
      '{25'h0010000, 1'b0, 1'b0, 1'b0}},
    '{3'(pac_pkg::OP_SUB), 25'h1000000, 25'h0FFFFFF, 1'b0, 1'b1,
      '{25'h0000000, 1'b0, 1'b0, 1'b0}},
    '{3'(pac_pkg::OP_MUL), 25'h1000000, 25'h1000000, 1'b0, 1'b1,
      '{25'h0010000, 1'b0, 1'b0, 1'b0}},
    // divisor -1 + bias 1 is zero
    '{3'(pac_pkg::OP_DIV), 25'h0000100, 25'h1FFFFFF, 1'b0, 1'b1,
      '{25'h0010000, 1'b0, 1'b1, 1'b0}},
    '{3'(pac_pkg::OP_DIV), 25'h0000000, 25'h1FFFFFF, 1'b1, 1'b1,
      '{25'h0000000, 1'b0, 1'b1, 1'b1}},
    '{3'(pac_pkg::OP_DIV), 25'h1000000, 25'h0000000, 1'b0, 1'b0,
      '{25'h0, 1'b0, 1'b0, 1'b0}},
    '{3'(pac_pkg::OP_DIV), 25'h0004000, 25'h0010000, 1'b0, 1'b0,
      '{25'h0, 1'b0, 1'b0, 1'b0}},
    // unused op gives zero
    '{3'd7, 25'h0FFFFFF, 25'h0FFFFFF, 1'b1, 1'b1, '{25'h0000000, 1'b0, 1'b0, 1'b1}}
  };

  task automatic run_random(int n);
    logic [2:0] op;
    logic [24:0] b;
    repeat (n) begin
      op = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      b = rand_pix();
      if (op == pac_pkg::OP_DIV && $urandom_range(0, 7) == 0) b = 25'(-bias_q);
      send_sample(op, rand_pix(), b, 1'($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    result_t w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].known) begin
        w = pixel_compute(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].last);
        if (w != dir_tab[i].res) report_mismatch("directed row", i, 0);
      end
      send_sample(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].last);
    end
    drain();
    // unclamped scalar ops with a zero scalar: saturation and zero divisor
    reg_write(pac_pkg::REG_SKIP, 32'd1);
    reg_write(pac_pkg::REG_SCALAR, 32'd0);
    send_sample(3'(pac_pkg::OP_DIV_S), 25'h0000001, 25'h0, 1'b0);
    send_sample(3'(pac_pkg::OP_DIV_S), 25'h1FFFFFF, 25'h0, 1'b0);
    send_sample(3'(pac_pkg::OP_DIV_S), 25'h0, 25'h0, 1'b1);
    drain();
    reg_write(pac_pkg::REG_SCALAR, 32'h00FFFFFF);
    reg_write(pac_pkg::REG_BIAS, 32'h0000FFFF);
    send_sample(3'(pac_pkg::OP_ADD_S), 25'h0FFFFFF, 25'h0, 1'b0);
    send_sample(3'(pac_pkg::OP_MUL_S), 25'h1000000, 25'h0, 1'b0);
    run_random(N_RAND / 4);
    drain();
    reg_write(pac_pkg::REG_SCALAR, 32'hFF000000);
    reg_write(pac_pkg::REG_BIAS, 32'd0);
    run_random(N_RAND / 4);
    drain();
    reg_write(pac_pkg::REG_SKIP, 32'd0);
    reg_write(pac_pkg::REG_SCALAR, 32'($urandom_range(0, 200000)));
    reg_write(pac_pkg::REG_BIAS, 32'($urandom_range(1, 65535)));
    run_random(N_RAND / 4);
    drain();
    reg_write(pac_pkg::REG_SKIP, 32'd1);
    reg_write(pac_pkg::REG_SCALAR, 32'h00000100);
    reg_write(pac_pkg::REG_BIAS, 32'd1);
    run_random(N_RAND / 4);
    drain();
    $display("tb: %0d samples sent, %0d results checked", n_sent, n_recv);
    $display("tb: %0d zero divisor and %0d saturated results seen", n_dz, n_ovf);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(8 * 200000);
    $display("tb: failure");
    $finish;
  end
endmodule
